// ===== src/sha1md_pkg.sv =====
`default_nettype none
package sha1md_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_rsp_t;

  // queued request, already classified
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       ends;
  } q_item_t;

  typedef logic [4:0][31:0] word5_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned BlockW = 512;
  localparam int unsigned Rounds = 80;
  localparam int unsigned RndW   = 7;

  localparam word5_t HInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] KRound0 = 32'h5A827999;
  localparam logic [31:0] KRound1 = 32'h6ED9EBA1;
  localparam logic [31:0] KRound2 = 32'h8F1BBCDC;
  localparam logic [31:0] KRound3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [2:0] LastIdx = 3'd4;

endpackage
`default_nettype wire

// ===== src/sha1_message_digest.sv =====
// Streaming SHA-1 digest unit.
// Input channel (in_valid_i/in_ready_o/in_req_i): one request per message byte,
// byte_valid marks a real byte, last ends the message; last with no byte ends an
// empty or block-aligned message. Requests with neither flag are taken and dropped.
// Output channel (out_valid_o/out_ready_i/out_rsp_o): five words h0..h4 per
// message, word_index 0..4, last_word set on h4.
// A two-entry queue sits between intake and the hashing engine.
// The engine appends one byte at a time; each full block then runs 80 rounds on
// one shared round unit and a fold into the chain before the next byte is taken.
// On last the engine pads one byte per cycle, pausing while a block is compressed
// (up to 72 bytes, one or two compressions), then issues the five words, one per
// cycle when not stalled. Reset loads the initial chaining values, clears the
// length and empties the queue. A stalled receiver holds the output register;
// the engine then waits before the next word, and intake stops once the queue is
// full.
`default_nettype none
module sha1_message_digest (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire sha1md_pkg::in_req_t  in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sha1md_pkg::out_rsp_t      out_rsp_o
);

  logic                q_valid;
  logic                q_pop;
  sha1md_pkg::q_item_t q_item;

  sha1md_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  sha1md_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== src/sha1md_front.sv =====
`default_nettype none
module sha1md_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sha1md_pkg::in_req_t in_req_i,
  output logic                     q_valid_o,
  output sha1md_pkg::q_item_t      q_item_o,
  input  wire logic                q_pop_i
);

  sha1md_pkg::q_item_t            mem_q [sha1md_pkg::QDepth];
  logic [sha1md_pkg::QIdxW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [sha1md_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                           push;
  logic                           pop;

  // requests with neither a byte nor an end marker carry no work
  assign in_ready_o = (cnt_q != sha1md_pkg::QCntW'(sha1md_pkg::QDepth));
  assign push = in_valid_i && in_ready_o && (in_req_i.byte_valid || in_req_i.last);
  assign pop  = q_pop_i && (cnt_q != '0);

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == sha1md_pkg::QIdxW'(sha1md_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == sha1md_pkg::QIdxW'(sha1md_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: in_req_i.data_byte, has_byte: in_req_i.byte_valid,
                       ends: in_req_i.last};
    end
  end

endmodule
`default_nettype wire

// ===== src/sha1md_round.sv =====
`default_nettype none
module sha1md_round (
  input  wire sha1md_pkg::word5_t           v_i,
  input  wire logic [sha1md_pkg::BlockW-1:0] blk_i,
  input  wire logic [sha1md_pkg::RndW-1:0]   rnd_i,
  output sha1md_pkg::word5_t                v_o,
  output logic [31:0]                       w_new_o
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, wt, sched;

  assign a  = v_i[0];
  assign b  = v_i[1];
  assign c  = v_i[2];
  assign d  = v_i[3];
  assign e  = v_i[4];
  assign wt = blk_i[511:480];

  // W[t+16] from W[t+13], W[t+8], W[t+2], W[t]
  assign sched   = blk_i[95:64] ^ blk_i[255:224] ^ blk_i[447:416] ^ blk_i[511:480];
  assign w_new_o = {sched[30:0], sched[31]};

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1md_pkg::KRound0;
    end else if (rnd_i < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1md_pkg::KRound1;
    end else if (rnd_i < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1md_pkg::KRound2;
    end else begin
      f = b ^ c ^ d;
      k = sha1md_pkg::KRound3;
    end
  end

  assign v_o[0] = {a[26:0], a[31:27]} + f + e + k + wt;
  assign v_o[1] = a;
  assign v_o[2] = {b[1:0], b[31:2]};
  assign v_o[3] = c;
  assign v_o[4] = d;

endmodule
`default_nettype wire

// ===== src/sha1md_back.sv =====
`default_nettype none
module sha1md_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire sha1md_pkg::q_item_t q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sha1md_pkg::out_rsp_t     out_rsp_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [2:0]                        state_q, state_d;
  logic [1:0]                        phase_q, phase_d;
  logic                              pad_q, pad_d;
  logic [5:0]                        fill_q, fill_d;
  logic [63:0]                       len_q, len_d;
  logic [sha1md_pkg::BlockW-1:0]     blk_q, blk_d;
  sha1md_pkg::word5_t                h_q, h_d;
  sha1md_pkg::word5_t                v_q, v_d;
  logic [sha1md_pkg::RndW-1:0]       rnd_q, rnd_d;
  logic [2:0]                        widx_q, widx_d;
  logic                              out_valid_q, out_valid_d;
  sha1md_pkg::out_rsp_t              out_q, out_d;

  sha1md_pkg::word5_t                v_rnd;
  logic [31:0]                       w_new;
  logic                              app;
  logic [7:0]                        app_byte;

  sha1md_round u_round (
    .v_i     (v_q),
    .blk_i   (blk_q),
    .rnd_i   (rnd_q),
    .v_o     (v_rnd),
    .w_new_o (w_new)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pad_d       = pad_q;
    fill_d      = fill_q;
    len_d       = len_q;
    blk_d       = blk_q;
    h_d         = h_q;
    v_d         = v_q;
    rnd_d       = rnd_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    app         = 1'b0;
    app_byte    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.has_byte) begin
            app      = 1'b1;
            app_byte = q_item_i.data;
            len_d    = len_q + 64'd8;
          end
          if (q_item_i.ends) begin
            pad_d   = 1'b1;
            phase_d = PH_MARK;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        app = 1'b1;
        case (phase_q)
          PH_MARK: begin
            app_byte = sha1md_pkg::PadMark;
            phase_d  = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_q == 6'd56) begin
              app_byte = len_q[63:56];
              len_d    = {len_q[55:0], 8'h00};
              phase_d  = PH_LEN;
            end
          end
          default: begin
            app_byte = len_q[63:56];
            len_d    = {len_q[55:0], 8'h00};
          end
        endcase
      end
      ST_COMP: begin
        v_d   = v_rnd;
        blk_d = {blk_q[sha1md_pkg::BlockW-33:0], w_new};
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == sha1md_pkg::RndW'(sha1md_pkg::Rounds - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        widx_d = '0;
        if (pad_q && phase_q == PH_LEN) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{digest_word: h_q[widx_q], word_index: widx_q,
                          last_word: (widx_q == sha1md_pkg::LastIdx)};
          widx_d      = widx_q + 1'b1;
          if (widx_q == sha1md_pkg::LastIdx) begin
            h_d     = sha1md_pkg::HInit;
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // byte into the block; a full block starts the compression
    if (app) begin
      blk_d  = {blk_q[sha1md_pkg::BlockW-9:0], app_byte};
      fill_d = fill_q + 1'b1;
      if (fill_q == 6'd63) begin
        v_d     = h_q;
        rnd_d   = '0;
        state_d = ST_COMP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MARK;
      pad_q       <= 1'b0;
      fill_q      <= '0;
      len_q       <= '0;
      h_q         <= sha1md_pkg::HInit;
      rnd_q       <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pad_q       <= pad_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      h_q         <= h_d;
      rnd_q       <= rnd_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMP |-> rnd_q < sha1md_pkg::RndW'(sha1md_pkg::Rounds))
    else $error("round counter beyond last round");

  a_len_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && phase_q == PH_LEN) |-> fill_q >= 6'd56)
    else $error("length bytes outside block tail");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.last_word == (out_rsp_o.word_index == sha1md_pkg::LastIdx)))
    else $error("last word flag mismatch");

  a_comp_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMP |-> fill_q == 6'd0)
    else $error("compression started on partial block");

endmodule
`default_nettype wire

// ===== tb/sha1_digest_checker.sv =====
`timescale 1ns / 100ps
module sha1_digest_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  sha1md_pkg::in_req_t  in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  sha1md_pkg::out_rsp_t out_rsp_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [31:0]          chain_h [5];
  logic [31:0]          block_w [16];
  logic [63:0]          msg_bits;
  int unsigned          fill_pos;
  sha1md_pkg::out_rsp_t digest_q [$];
  int                   fails = 0;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 5; i++) chain_h[i] = sha1md_pkg::HInit[i];
    msg_bits = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = block_w[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < sha1md_pkg::Rounds; i++) begin
      if (i >= 16) begin
        w[i % 16] = rotl(w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16], 1);
      end
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::KRound0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::KRound1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::KRound2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::KRound3;
      end
      t = rotl(a, 5) + f + e + k + w[i % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    block_w[fill_pos / 4][(3 - fill_pos % 4) * 8 +: 8] = v;
    fill_pos++;
    if (fill_pos == 64) begin
      fold_block();
      fill_pos = 0;
    end
  endfunction

  function automatic void take_request(sha1md_pkg::in_req_t r);
    logic [63:0]          len;
    sha1md_pkg::out_rsp_t dw;
    if (r.byte_valid) begin
      put_byte(r.data_byte);
      msg_bits += 64'd8;
    end
    if (r.last) begin
      len = msg_bits;
      put_byte(sha1md_pkg::PadMark);
      while (fill_pos != 56) put_byte(8'h00);
      block_w[14] = len[63:32];
      block_w[15] = len[31:0];
      fold_block();
      fill_pos = 0;
      for (int i = 0; i < 5; i++) begin
        dw.digest_word = chain_h[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (3'(i) == sha1md_pkg::LastIdx);
        digest_q.insert(digest_q.size(), dw);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sha1md_pkg::out_rsp_t want;
    if (!rst_ni) begin
      restart_message();
      fill_pos = 0;
      digest_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) take_request(in_req_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("digest_word: none due, got %h (word_index %0d)",
                 out_rsp_i.digest_word, out_rsp_i.word_index);
          fails++;
        end else begin
          want = digest_q.pop_front();
          if (out_rsp_i.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, out_rsp_i.digest_word);
            fails++;
          end
          if (out_rsp_i.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, out_rsp_i.word_index);
            fails++;
          end
          if (out_rsp_i.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word, out_rsp_i.last_word);
            fails++;
          end
        end
      end
    end
    pending_o    <= digest_q.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb_sha1_message_digest.sv =====
`timescale 1ns / 100ps
module tb_sha1_message_digest;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  sha1md_pkg::in_req_t  in_req    = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sha1md_pkg::out_rsp_t out_rsp;
  idle_mode_e           idle_mode = IdleNone;
  int                   hold_asks = 0;
  int                   hold_done = 0;
  int unsigned          hold_left = 0;
  int unsigned          cycles    = 0;
  int unsigned          requests  = 0;
  int                   fail_count;
  int                   pending;

  always #6 clk_i = ~clk_i;

  sha1_message_digest uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  sha1_digest_checker digest_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver: random stalls in IdleReceiver and IdleBoth modes, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= ((idle_mode == IdleReceiver) ? 55 :
                                          (idle_mode == IdleBoth) ? 29 : 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("sha1_message_digest: mismatch");
      $finish;
    end
  end

  task automatic send_request(logic [7:0] data, logic has_byte, logic ends);
    int unsigned pct;
    int unsigned gap;
    in_req   <= '{data_byte: data, byte_valid: has_byte, last: ends};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pct = (idle_mode == IdleSender) ? 55 : (idle_mode == IdleBoth) ? 29 : 0;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // well-formed message with random bytes; noisy adds ignored requests between bytes
  task automatic send_message(int unsigned n, bit bare_end, bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(99) < 8) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, !bare_end && i == n - 1);
      requests++;
    end
    if (bare_end || n == 0) begin
      send_request(8'($urandom_range(255)), 1'b0, 1'b1);
      requests++;
    end
  endtask

  task automatic wait_digests();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(8'hFF, 1'b0, 1'b0);  // ignored
    send_request(8'hA5, 1'b0, 1'b1);  // empty message
    send_request(8'h61, 1'b1, 1'b0);  // "abc"
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);  // ignored
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h3C, 1'b0, 1'b1);  // bare end
    send_request(8'hFF, 1'b1, 1'b1);
    wait_digests();

    idle_mode <= IdleSender;
    send_message(64, 1'b1, 1'b0);     // block-aligned, bare end
    idle_mode <= IdleReceiver;
    send_message(56, 1'b0, 1'b0);     // padding spills into a second block
    wait_digests();

    idle_mode <= IdleNone;
    hold_asks <= hold_asks + 1;
    for (int m = 0; m < 5; m++) begin
      if (m >= 3) idle_mode <= idle_mode_e'(m % 4);
      send_message($urandom_range(4), 1'($urandom_range(1)), 1'b1);
    end

    wait_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sha1_message_digest: match");
    end else begin
      $display("sha1_message_digest: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sha1md_pkg.sv
src/sha1md_front.sv
src/sha1md_round.sv
src/sha1md_back.sv
src/sha1_message_digest.sv
tb/sha1_digest_checker.sv
tb/tb_sha1_message_digest.sv
